@@ hdl/lmfs_pkg.sv @@
package lmfs_pkg;

  // Default panel geometry in pixels.
  localparam int DEF_PANEL_WIDTH  = 64;
  localparam int DEF_PANEL_HEIGHT = 32;

  // Lines per scan band and width of the row select.
  localparam int BAND_LINES = 16;
  localparam int ROW_SEL_W  = 4;

  // Pixel coordinate widths wide enough for the end of any rectangle and
  // for the largest panel.
  localparam int PIX_XW = 9;
  localparam int PIX_YW = 7;

  typedef enum logic [1:0] {
    FUNC_FILL  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_LATCH = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] x_start;
    logic [4:0] y_start;
    logic [6:0] rect_width;
    logic [5:0] rect_height;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic                 item_kind;
    logic [7:0]           column_byte;
    logic [ROW_SEL_W-1:0] row_select;
    logic                 last;
  } out_item_t;

endpackage

@@ hdl/led_matrix_frame_scan_core.sv @@
// Row-scan driver for a one-bit-per-pixel LED matrix panel.
//
// A request is taken at a rising edge where start is high and busy is low.
// Its func field selects one of three operations. A fill request sets or
// clears a rectangle of pixels, clipped to the panel; it reads and rewrites
// each touched frame store byte, passing through a read state and then a
// write state for each byte, and gives no results. A clear request sweeps
// the whole store to zero at one byte per cycle and gives no results either.
// A scan request gives PANEL_WIDTH/8 column bytes for each 16-line band,
// followed by one latch result carrying the row select and last, after which
// the 4-bit row counter advances. The rate of a scan is set by the single
// read port of the store, which delivers one byte per cycle. Unused func
// codes are ignored.
//
// Each result is shown for exactly one cycle with out_valid high; the
// receiver cannot stall the block, so no result is ever held back.
// After reset the block runs the same clearing pass as a clear request,
// holding busy high until the whole store is zero, and the row counter
// returns to zero.
module led_matrix_frame_scan_core
  import lmfs_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int ROW_BYTES   = PANEL_WIDTH / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int NUM_BANDS   = PANEL_HEIGHT / BAND_LINES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int BW          = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam logic [AW-1:0]     ROW_STEP   = AW'(ROW_BYTES);
  localparam logic [AW-1:0]     BAND_STEP  = AW'(BAND_LINES * ROW_BYTES);
  localparam logic [AW-1:0]     LAST_ADDR  = AW'(STORE_BYTES - 1);
  localparam logic [CW-1:0]     LAST_COL   = CW'(ROW_BYTES - 1);
  localparam logic [BW-1:0]     LAST_BAND  = BW'(NUM_BANDS - 1);
  localparam logic [PIX_XW-1:0] PIX_WIDTH  = PIX_XW'(PANEL_WIDTH);
  localparam logic [PIX_YW-1:0] PIX_HEIGHT = PIX_YW'(PANEL_HEIGHT);

  // The sequencer: one-hot states.
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CLEAR    = 7'b0000010,
    S_FILL_RD  = 7'b0000100,
    S_FILL_WR  = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_SCAN_END = 7'b0100000,
    S_LATCH    = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [BW-1:0]        band_r, band_nxt;
  logic [ROW_SEL_W-1:0] scan_row_r, scan_row_nxt;
  logic                 rd_pend_r, rd_pend_nxt;

  // Fill rectangle, clipped to the panel.
  logic [PIX_XW-1:0]    xlo_r, xlo_nxt;
  logic [PIX_XW-1:0]    xhi_r, xhi_nxt;
  logic [CW-1:0]        clo_r, clo_nxt;
  logic [CW-1:0]        chi_r, chi_nxt;
  logic [PIX_YW-1:0]    y_r, y_nxt;
  logic [PIX_YW-1:0]    ylast_r, ylast_nxt;
  logic                 color_r, color_nxt;

  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [AW-1:0]        cur_addr;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [7:0]           ram_wr_data;
  logic [7:0]           ram_rd_data;
  logic [7:0]           pix_mask;

  logic [PIX_XW-1:0]    x_end;
  logic [PIX_XW-1:0]    x_hi;
  logic [PIX_YW-1:0]    y_end;
  logic [PIX_YW-1:0]    y_hi;
  logic                 fill_empty;
  logic                 accept;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cur_addr = base_r + AW'(col_r);

  // Clipping of the requested rectangle against the panel edges.
  assign x_end = PIX_XW'(in_item.x_start) + PIX_XW'(in_item.rect_width);
  assign x_hi  = (x_end < PIX_WIDTH) ? x_end : PIX_WIDTH;
  assign y_end = PIX_YW'(in_item.y_start) + PIX_YW'(in_item.rect_height);
  assign y_hi  = (y_end < PIX_HEIGHT) ? y_end : PIX_HEIGHT;
  assign fill_empty = (in_item.rect_width == '0) || (in_item.rect_height == '0) ||
                      (PIX_XW'(in_item.x_start) >= PIX_WIDTH) ||
                      (PIX_YW'(in_item.y_start) >= PIX_HEIGHT);

  // Pixels of the current byte that fall inside the rectangle; the leftmost
  // pixel sits in the most significant bit.
  always_comb begin
    logic [PIX_XW-1:0] pcol;
    pix_mask = '0;
    for (int j = 0; j < 8; j++) begin
      pcol = (PIX_XW'(col_r) << 3) + PIX_XW'(j);
      pix_mask[7-j] = (pcol >= xlo_r) && (pcol < xhi_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    base_nxt     = base_r;
    col_nxt      = col_r;
    band_nxt     = band_r;
    scan_row_nxt = scan_row_r;
    rd_pend_nxt  = 1'b0;
    xlo_nxt      = xlo_r;
    xhi_nxt      = xhi_r;
    clo_nxt      = clo_r;
    chi_nxt      = chi_r;
    y_nxt        = y_r;
    ylast_nxt    = ylast_r;
    color_nxt    = color_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cur_addr;
    ram_wr_data  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FUNC_FILL: begin
              if (!fill_empty) begin
                xlo_nxt   = PIX_XW'(in_item.x_start);
                xhi_nxt   = x_hi;
                clo_nxt   = CW'(in_item.x_start >> 3);
                chi_nxt   = CW'((x_hi - PIX_XW'(1)) >> 3);
                col_nxt   = CW'(in_item.x_start >> 3);
                y_nxt     = PIX_YW'(in_item.y_start);
                ylast_nxt = y_hi - PIX_YW'(1);
                base_nxt  = AW'(in_item.y_start) * ROW_STEP;
                color_nxt = in_item.color;
                state_nxt = S_FILL_RD;
              end
            end
            FUNC_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            FUNC_SCAN: begin
              base_nxt  = AW'(scan_row_r) * ROW_STEP;
              col_nxt   = '0;
              band_nxt  = '0;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_FILL_RD: begin
        state_nxt = S_FILL_WR;
      end

      S_FILL_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = color_r ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);
        state_nxt   = S_FILL_RD;
        if (col_r == chi_r) begin
          col_nxt  = clo_r;
          y_nxt    = y_r + PIX_YW'(1);
          base_nxt = base_r + ROW_STEP;
          if (y_r == ylast_r) begin
            state_nxt = S_IDLE;
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      S_SCAN: begin
        rd_pend_nxt = 1'b1;
        if (col_r == LAST_COL) begin
          col_nxt = '0;
          if (band_r == LAST_BAND) begin
            state_nxt = S_SCAN_END;
          end else begin
            band_nxt = band_r + BW'(1);
            base_nxt = base_r + BAND_STEP;
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      S_SCAN_END: begin
        state_nxt = S_LATCH;
      end

      S_LATCH: begin
        scan_row_nxt = scan_row_r + ROW_SEL_W'(1);
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      scan_row_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_row_r  <= scan_row_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= rd_pend_r || (state_r == S_LATCH);
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    col_r   <= col_nxt;
    band_r  <= band_nxt;
    xlo_r   <= xlo_nxt;
    xhi_r   <= xhi_nxt;
    clo_r   <= clo_nxt;
    chi_r   <= chi_nxt;
    y_r     <= y_nxt;
    ylast_r <= ylast_nxt;
    color_r <= color_nxt;
    if (rd_pend_r) begin
      out_item_r.item_kind   <= KIND_DATA;
      out_item_r.column_byte <= ram_rd_data;
      out_item_r.row_select  <= '0;
      out_item_r.last        <= 1'b0;
    end else if (state_r == S_LATCH) begin
      out_item_r.item_kind   <= KIND_LATCH;
      out_item_r.column_byte <= '0;
      out_item_r.row_select  <= scan_row_r;
      out_item_r.last        <= 1'b1;
    end
  end

  lmfs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (cur_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hdl/lmfs_ram.sv @@
module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lmfs_checker.sv @@
module lmfs_checker
  import lmfs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // Reset starts the clearing pass and drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("block not busy clearing after reset");

  // A scan request always occupies the block.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.func == FUNC_SCAN |=> busy)
    else $error("scan request did not start");

  // Data bytes carry no row select and never end a run.
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.item_kind == KIND_DATA |->
      out_item.row_select == '0 && !out_item.last)
    else $error("data result with latch fields set");

  // A latch result ends the run and carries an empty byte.
  a_latch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.item_kind == KIND_LATCH |->
      out_item.last && out_item.column_byte == '0)
    else $error("latch result malformed");

  // Nothing follows a latch immediately.
  a_latch_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result straight after the latch");

endmodule

bind led_matrix_frame_scan_core lmfs_checker u_lmfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
